### sv/ial_pkg.sv
package ial_pkg;

    // List geometry
    localparam int CAPACITY     = 64;
    localparam int ELEMENT_BITS = 32;
    localparam int ADDR_W       = $clog2(CAPACITY);
    localparam int LEN_W        = $clog2(CAPACITY + 1);

    // Operation codes
    typedef enum logic [1:0] {
        OP_APPEND = 2'd0,
        OP_INSERT = 2'd1,
        OP_GET    = 2'd2,
        OP_REMOVE = 2'd3
    } t_opcode;

    // Result status codes
    typedef enum logic [1:0] {
        ST_OK     = 2'd0,
        ST_BOUNDS = 2'd1,
        ST_FULL   = 2'd2
    } t_status;

    // Sequencer states
    typedef enum logic [2:0] {
        S_IDLE,
        S_SCAN,
        S_DRAIN,
        S_LAST,
        S_DONE
    } t_state;

endpackage

### sv/ial_ram.sv
module ial_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64,
    localparam int AW = $clog2(DEPTH)
) (
    input  logic             i_clk,
    input  logic             i_wr_en,
    input  logic [AW-1:0]    i_wr_addr,
    input  logic [WIDTH-1:0] i_wr_data,
    input  logic             i_rd_en,
    input  logic [AW-1:0]    i_rd_addr,
    output logic [WIDTH-1:0] o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    // One write port, one registered read port
    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

### sv/indexed_array_list.sv
// Indexed array list: an ordered list of up to 64 words kept in one RAM.
// Input channel (i_in_valid / o_in_ready) carries one operation per transfer:
// append, insert at a position, get at a position, or remove at a position.
// Output channel (o_out_valid / i_out_ready) returns one result per operation:
// the element read or removed, a status and the list length afterwards.
// An error goes straight to the done state, an append at the end skips the
// scan and goes to the final write, a get reads the entry at the position, and
// insert and remove scan the entries at or above the position. Each of those
// entries costs one RAM read and, when moved, one RAM write, pipelined at one
// entry per cycle through the registered read port. The next operation is
// taken once the result is loaded and the sequencer is back in idle; the
// longest operation is a remove at position 0 of a full list.
// One operation is in work at a time; a new one is taken as soon as the
// previous result sits in the output register, even if it is not yet taken.
// If the receiver stalls, the finished operation waits in the done state
// until the output register frees up, and the input stays not ready.
// Reset empties the list (length zero); RAM contents are not cleared and are
// never read outside the stored length.
module indexed_array_list (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_in_valid,
    output logic                                o_in_ready,
    input  ial_pkg::t_opcode                    i_opcode,
    input  logic [6:0]                          i_position,
    input  logic [31:0]                         i_element_value,
    output logic                                o_out_valid,
    input  logic                                i_out_ready,
    output logic [31:0]                         o_element_out,
    output ial_pkg::t_status                    o_status,
    output logic [6:0]                          o_list_length
);

    import ial_pkg::*;

    t_state                  r_state, n_state;
    t_opcode                 r_op;
    t_status                 r_status;
    logic [ADDR_W-1:0]       r_pos;
    logic [ADDR_W-1:0]       r_ptr;
    logic [ADDR_W-1:0]       r_end;
    logic [ELEMENT_BITS-1:0] r_val;
    logic [ELEMENT_BITS-1:0] r_elem;
    logic [LEN_W-1:0]        r_len;
    logic                    r_pend;
    logic                    r_pend_cap;
    logic [ADDR_W-1:0]       r_pend_waddr;
    logic                    r_out_valid;
    logic [31:0]             r_out_elem;
    t_status                 r_out_status;
    logic [6:0]              r_out_len;

    logic                    w_accept;
    logic                    w_out_free;
    logic [LEN_W-1:0]        w_pos;
    logic [LEN_W-1:0]        w_len_m1;
    logic                    w_is_add;
    logic                    w_bounds;
    logic                    w_full;
    t_status                 w_status;
    logic                    w_no_shift;
    logic [LEN_W-1:0]        w_new_len;

    logic                    ram_wr_en;
    logic [ADDR_W-1:0]       ram_wr_addr;
    logic [ELEMENT_BITS-1:0] ram_wr_data;
    logic                    ram_rd_en;
    logic [ADDR_W-1:0]       ram_rd_addr;
    logic [ELEMENT_BITS-1:0] ram_rd_data;

    ial_ram #(
        .WIDTH (ELEMENT_BITS),
        .DEPTH (CAPACITY)
    ) u_ram (
        .i_clk     (i_clk),
        .i_wr_en   (ram_wr_en),
        .i_wr_addr (ram_wr_addr),
        .i_wr_data (ram_wr_data),
        .i_rd_en   (ram_rd_en),
        .i_rd_addr (ram_rd_addr),
        .o_rd_data (ram_rd_data)
    );

    // Checks on the incoming operation
    assign w_accept   = i_in_valid && o_in_ready;
    assign w_out_free = !r_out_valid || i_out_ready;
    assign w_is_add   = (i_opcode == OP_APPEND) || (i_opcode == OP_INSERT);
    assign w_pos      = (i_opcode == OP_APPEND) ? r_len : LEN_W'(i_position);
    assign w_len_m1   = r_len - LEN_W'(1);

    always_comb begin
        if (w_is_add) begin
            w_bounds = w_pos > r_len;
        end else begin
            w_bounds = w_pos >= r_len;
        end
        w_full = w_is_add && (r_len >= LEN_W'(CAPACITY));
        if (w_bounds) begin
            w_status = ST_BOUNDS;
        end else if (w_full) begin
            w_status = ST_FULL;
        end else begin
            w_status = ST_OK;
        end
        w_no_shift = w_is_add && (w_pos == r_len);
    end

    // Length after the operation in work
    always_comb begin
        w_new_len = r_len;
        if (r_status == ST_OK) begin
            case (r_op)
                OP_APPEND, OP_INSERT: w_new_len = r_len + LEN_W'(1);
                OP_REMOVE:            w_new_len = r_len - LEN_W'(1);
                default:              w_new_len = r_len;
            endcase
        end
    end

    // Next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (w_accept) begin
                    if (w_status != ST_OK) begin
                        n_state = S_DONE;
                    end else if (w_no_shift) begin
                        n_state = S_LAST;
                    end else begin
                        n_state = S_SCAN;
                    end
                end
            end
            S_SCAN: begin
                if (r_ptr == r_end) begin
                    n_state = S_DRAIN;
                end
            end
            S_DRAIN: n_state = S_LAST;
            S_LAST:  n_state = S_DONE;
            S_DONE: begin
                if (w_out_free) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    // RAM port control and input handshake
    always_comb begin
        o_in_ready  = 1'b0;
        ram_rd_en   = 1'b0;
        ram_rd_addr = r_ptr;
        ram_wr_en   = 1'b0;
        ram_wr_addr = r_pend_waddr;
        ram_wr_data = ram_rd_data;
        // data read last cycle lands one slot over
        if (r_pend && !r_pend_cap) begin
            ram_wr_en = 1'b1;
        end
        case (r_state)
            S_IDLE: o_in_ready = 1'b1;
            S_SCAN: ram_rd_en = 1'b1;
            S_LAST: begin
                if (r_op == OP_REMOVE) begin
                    ram_wr_en   = 1'b1;
                    ram_wr_addr = r_end;
                    ram_wr_data = '0;
                end else if (r_op == OP_APPEND || r_op == OP_INSERT) begin
                    ram_wr_en   = 1'b1;
                    ram_wr_addr = r_pos;
                    ram_wr_data = r_val;
                end
            end
            default: o_in_ready = 1'b0;
        endcase
    end

    // Control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_len       <= '0;
            r_pend      <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_pend  <= (r_state == S_SCAN);
            if (r_state == S_DONE && w_out_free) begin
                r_len       <= w_new_len;
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Operation and scan registers
    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_op     <= i_opcode;
            r_status <= w_status;
            r_val    <= i_element_value;
            r_elem   <= '0;
            r_pos    <= w_pos[ADDR_W-1:0];
            case (i_opcode)
                OP_APPEND, OP_INSERT: begin
                    r_ptr <= w_len_m1[ADDR_W-1:0];
                    r_end <= w_pos[ADDR_W-1:0];
                end
                OP_REMOVE: begin
                    r_ptr <= w_pos[ADDR_W-1:0];
                    r_end <= w_len_m1[ADDR_W-1:0];
                end
                default: begin
                    r_ptr <= w_pos[ADDR_W-1:0];
                    r_end <= w_pos[ADDR_W-1:0];
                end
            endcase
        end
        if (r_state == S_SCAN) begin
            // shift up walks down from the top, shift down walks up
            if (r_op == OP_APPEND || r_op == OP_INSERT) begin
                r_ptr        <= r_ptr - ADDR_W'(1);
                r_pend_waddr <= r_ptr + ADDR_W'(1);
            end else begin
                r_ptr        <= r_ptr + ADDR_W'(1);
                r_pend_waddr <= r_ptr - ADDR_W'(1);
            end
            r_pend_cap <= (r_op == OP_GET) || (r_op == OP_REMOVE && r_ptr == r_pos);
        end
        if (r_pend && r_pend_cap) begin
            r_elem <= ram_rd_data;
        end
        if (r_state == S_DONE && w_out_free) begin
            r_out_elem   <= 32'(r_elem);
            r_out_status <= r_status;
            r_out_len    <= 7'(w_new_len);
        end
    end

    assign o_out_valid   = r_out_valid;
    assign o_element_out = r_out_elem;
    assign o_status      = r_out_status;
    assign o_list_length = r_out_len;

    // Stored length never passes the capacity
    a_len_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_len <= LEN_W'(CAPACITY))
        else $error("list length beyond capacity");

    // The final write never collides with a shift write
    a_last_no_pend: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_LAST) |-> !r_pend)
        else $error("shift write pending during final write");

    // The shift never reads the entry it writes in the same cycle
    a_rw_apart: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (ram_wr_en && ram_rd_en) |-> (ram_wr_addr != ram_rd_addr))
        else $error("RAM read and write hit the same entry");

    // A finished operation reaches the output register
    a_done_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_DONE && w_out_free) |=> (o_out_valid && r_state == S_IDLE))
        else $error("result not loaded on completion");

    // Input is taken only when no operation is in work
    a_one_op: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_accept |=> (r_state != S_IDLE))
        else $error("operation accepted but sequencer stayed idle");

endmodule
